// ===== rtl/bridge_offset_autocalibrator_unit_assert.svh =====
`ifndef BRIDGE_OFFSET_AUTOCALIBRATOR_UNIT_ASSERT_SVH
`define BRIDGE_OFFSET_AUTOCALIBRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BOAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BOAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/boac_pkg.sv =====
package boac_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TH_W     = 15;
    localparam int SENSOR_W = 2;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 7;
    localparam int STEP_W   = 6;

    localparam int AVG_LOG2  = 4;
    localparam int AVG_COUNT = 1 << AVG_LOG2;
    localparam int CNT_W     = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
    localparam int ACC_W     = SAMPLE_W + AVG_LOG2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SENSOR_W-1:0]        sensor_t;
    typedef logic [KIND_W-1:0]          kind_t;
    typedef logic [BYTE_W-1:0]          offset_byte_t;
    typedef logic [STEP_W-1:0]          step_t;
    typedef logic [TH_W-1:0]            threshold_t;

    localparam threshold_t TH_RESET = 15'd5460;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam kind_t KIND_WRITE = 2'd0;
    localparam kind_t KIND_DONE  = 2'd1;
    localparam kind_t KIND_FAIL  = 2'd2;

    localparam step_t STEP_MAX  = 6'd63;
    localparam step_t STEP_ZERO = 6'd0;
    localparam step_t STEP_ONE  = 6'd1;

endpackage

// ===== rtl/bridge_offset_autocalibrator_unit.sv =====
// A beat is captured in the input register and its result, if it has one, is then
// registered in the result register, which a stalling sink holds.
// Throughput: one input beat per cycle; the input register stalls only while
// it is full and the result register holds a beat that the sink is stalling.
// Reset: asynchronous, active low; calibration goes idle, threshold returns
// to 5460 and both the input and the result registers are emptied.
module bridge_offset_autocalibrator_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  threshold_we,
    input  boac_pkg::threshold_t  threshold_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  boac_pkg::sensor_t     sensor,
    input  boac_pkg::sample_t     sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output boac_pkg::kind_t       kind,
    output boac_pkg::sensor_t     sensor_out,
    output boac_pkg::offset_byte_t offset_byte,
    output boac_pkg::sample_t     residual
);
    import boac_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_STEP  = 2'd2;

    threshold_t th_reg;

    logic    s1_valid_reg, s1_valid_next;
    logic    s1_op_reg;
    sensor_t s1_sensor_reg;
    sample_t s1_sample_reg;

    logic [1:0]              phase_reg, phase_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    step_t                   step_reg, step_next;
    logic                    neg_reg, neg_next;
    sensor_t                 act_reg, act_next;

    logic         out_valid_reg, out_valid_next;
    kind_t        kind_reg, kind_next;
    sensor_t      sensor_out_reg, sensor_out_next;
    offset_byte_t byte_reg, byte_next;
    sample_t      residual_reg, residual_next;

    logic in_accept;
    logic out_free;
    logic advance;

    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  quot;
    sample_t                  avg;
    logic signed [SAMPLE_W:0] avg_x;
    logic signed [SAMPLE_W:0] th_x;
    logic signed [SAMPLE_W:0] nth_x;
    logic                     above;
    logic                     below;
    logic                     group_end;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Truncation toward zero: negative sums are biased before the shift.
    assign sum       = acc_reg + ACC_W'(s1_sample_reg);
    assign biased    = sum + (sum[ACC_W-1] ? ACC_W'(AVG_COUNT - 1) : ACC_W'(0));
    assign quot      = biased >>> AVG_LOG2;
    assign avg       = quot[SAMPLE_W-1:0];
    assign avg_x     = (SAMPLE_W+1)'(avg);
    assign th_x      = (SAMPLE_W+1)'(th_reg);
    assign nth_x     = -th_x;
    assign above     = avg_x > th_x;
    assign below     = avg_x < nth_x;
    assign group_end = (cnt_reg == CNT_W'(AVG_COUNT - 1));

    assign s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        act_next        = act_reg;
        out_valid_next  = out_valid_reg && !out_free;
        kind_next       = kind_reg;
        sensor_out_next = sensor_out_reg;
        byte_next       = byte_reg;
        residual_next   = residual_reg;

        if (advance)
        begin
            if (s1_op_reg == OP_START)
            begin
                act_next        = s1_sensor_reg;
                step_next       = STEP_ZERO;
                neg_next        = 1'b0;
                cnt_next        = '0;
                acc_next        = '0;
                phase_next      = PH_FIRST;
                out_valid_next  = 1'b1;
                kind_next       = KIND_WRITE;
                sensor_out_next = s1_sensor_reg;
                byte_next       = '0;
                residual_next   = '0;
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (!group_end)
                begin
                    acc_next = sum;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    acc_next        = '0;
                    cnt_next        = '0;
                    out_valid_next  = 1'b1;
                    sensor_out_next = act_reg;
                    residual_next   = avg;
                    kind_next       = KIND_DONE;
                    byte_next       = {neg_reg, step_reg};
                    if (phase_reg == PH_FIRST)
                    begin
                        if (above || below)
                        begin
                            neg_next   = above;
                            step_next  = STEP_ONE;
                            phase_next = PH_STEP;
                            kind_next  = KIND_WRITE;
                            byte_next  = {above, STEP_ONE};
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (step_reg >= STEP_MAX)
                    begin
                        phase_next = PH_IDLE;
                        kind_next  = KIND_FAIL;
                    end
                    else if (neg_reg ? above : below)
                    begin
                        step_next = step_reg + STEP_ONE;
                        kind_next = KIND_WRITE;
                        byte_next = {neg_reg, step_reg + STEP_ONE};
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_reg        <= TH_RESET;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            step_reg      <= STEP_ZERO;
            neg_reg       <= 1'b0;
            act_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (threshold_we)
            begin
                th_reg <= threshold_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            neg_reg       <= neg_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= op;
            s1_sensor_reg <= sensor;
            s1_sample_reg <= sample;
        end
        kind_reg       <= kind_next;
        sensor_out_reg <= sensor_out_next;
        byte_reg       <= byte_next;
        residual_reg   <= residual_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign sensor_out  = sensor_out_reg;
    assign offset_byte = byte_reg;
    assign residual    = residual_reg;

`include "bridge_offset_autocalibrator_unit_assert.svh"

    `BOAU_ASSERT_NOW(a_fail_at_limit, out_valid_reg && kind_reg == KIND_FAIL, byte_reg[STEP_W-1:0] == STEP_MAX, "failure reported below the step limit")
    `BOAU_ASSERT_NOW(a_first_clean, phase_reg == PH_FIRST, step_reg == STEP_ZERO && !neg_reg, "offset not cleared during the first group")
    `BOAU_ASSERT_NOW(a_step_nonzero, phase_reg == PH_STEP, step_reg != STEP_ZERO, "stepping with a zero offset step")
    `BOAU_ASSERT_NOW(a_stall_full, in_stall, s1_valid_reg, "input stalled with an empty input register")
    `BOAU_ASSERT_NEXT(a_start_writes, advance && s1_op_reg == OP_START, out_valid_reg && kind_reg == KIND_WRITE && byte_reg == '0, "start did not emit an offset write of zero")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import boac_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 15;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_BURST   = 12;
    localparam int RANDOM_ITEMS = 340;
    localparam int PHASES       = 5;
    localparam int HOLD_PHASE   = 1;
    localparam int CALM_PHASE   = 2;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int NUM_ROWS     = 23;

    typedef enum logic [1:0] {CAL_IDLE, CAL_FIRST, CAL_STEP} cal_phase_t;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_RESULT} row_mode_t;

    typedef struct packed {
        kind_t        kind;
        sensor_t      sensor;
        offset_byte_t obyte;
        sample_t      residual;
    } cal_report_t;

    typedef struct {
        logic        op;
        sensor_t     sensor;
        sample_t     sample;
        int          reps;
        row_mode_t   mode;
        cal_report_t report;
    } stim_row_t;

    logic         clk             = 1'b0;
    logic         rst_n           = 1'b0;
    logic         threshold_we    = 1'b0;
    threshold_t   threshold_wdata = TH_RESET;
    logic         in_valid        = 1'b0;
    logic         in_stall;
    logic         op              = OP_START;
    sensor_t      sensor          = '0;
    sample_t      sample          = '0;
    logic         out_valid;
    logic         out_stall       = 1'b0;
    kind_t        kind;
    sensor_t      sensor_out;
    offset_byte_t offset_byte;
    sample_t      residual;

    cal_phase_t   cal_phase     = CAL_IDLE;
    int           cal_sum       = 0;
    int           cal_count     = 0;
    step_t        cal_step      = STEP_ZERO;
    logic         cal_neg       = 1'b0;
    sensor_t      cal_sensor    = '0;
    threshold_t   cal_threshold = TH_RESET;

    cal_report_t  awaited_reports[$];
    int           errors         = 0;
    int           beats_taken    = 0;
    int           hold_requests  = 0;
    int           holds_served   = 0;
    int           hold_left      = 0;
    bit           calm           = 1'b0;

    // Each row is repeated reps times; a typed report applies to the last beat only.
    stim_row_t directed [NUM_ROWS] = '{
        '{OP_SAMPLE, 2'd0, 16'sd0,     1,    ROW_SILENT,  '0},
        '{OP_START,  2'd3, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd3, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd0, 16'sd100,   16,   ROW_RESULT,  '{KIND_DONE, 2'd3, 7'h00, 16'sd100}},
        '{OP_SAMPLE, 2'd2, -16'sd1,    1,    ROW_SILENT,  '0},
        '{OP_START,  2'd1, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd1, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd1, 16'sd32767, 16,   ROW_RESULT,  '{KIND_WRITE, 2'd1, 7'h41, 16'sd32767}},
        '{OP_SAMPLE, 2'd1, 16'sh8000,  16,   ROW_RESULT,  '{KIND_DONE, 2'd1, 7'h41, 16'sh8000}},
        '{OP_START,  2'd2, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd2, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd2, 16'sh8000,  16,   ROW_RESULT,  '{KIND_WRITE, 2'd2, 7'h01, 16'sh8000}},
        '{OP_SAMPLE, 2'd2, -16'sd20000, 8,   ROW_PREDICT, '0},
        '{OP_START,  2'd0, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd0, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd0, 16'sd0,     15,   ROW_PREDICT, '0},
        '{OP_SAMPLE, 2'd0, -16'sd7,    1,    ROW_RESULT,  '{KIND_DONE, 2'd0, 7'h00, 16'sd0}},
        '{OP_START,  2'd1, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd1, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd1, 16'sd6000,  16,   ROW_RESULT,  '{KIND_WRITE, 2'd1, 7'h41, 16'sd6000}},
        '{OP_SAMPLE, 2'd1, 16'sd5461,  16,   ROW_RESULT,  '{KIND_WRITE, 2'd1, 7'h42, 16'sd5461}},
        '{OP_SAMPLE, 2'd1, 16'sd5460,  16,   ROW_RESULT,  '{KIND_DONE, 2'd1, 7'h42, 16'sd5460}},
        '{OP_START,  2'd3, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd3, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd3, -16'sd5461, 16,   ROW_RESULT,  '{KIND_WRITE, 2'd3, 7'h01, -16'sd5461}},
        '{OP_SAMPLE, 2'd3, -16'sd5460, 16,   ROW_RESULT,  '{KIND_DONE, 2'd3, 7'h01, -16'sd5460}},
        '{OP_START,  2'd2, 16'sd0,     1,    ROW_RESULT,  '{KIND_WRITE, 2'd2, 7'h00, 16'sd0}},
        '{OP_SAMPLE, 2'd2, 16'sd32767, 1008, ROW_PREDICT, '0},
        '{OP_SAMPLE, 2'd2, 16'sd0,     16,   ROW_RESULT,  '{KIND_FAIL, 2'd2, 7'h7F, 16'sd0}}
    };

    bridge_offset_autocalibrator_unit dut (.*);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic bit advance_calibration(input logic op_i, input sensor_t sens_i,
                                               input sample_t smp_i, output cal_report_t rep);
        int    avg;
        int    lim;
        bit    above;
        bit    below;
        kind_t k;
        rep = '0;
        if (op_i == OP_START)
        begin
            cal_sensor = sens_i;
            cal_step   = STEP_ZERO;
            cal_neg    = 1'b0;
            cal_count  = 0;
            cal_sum    = 0;
            cal_phase  = CAL_FIRST;
            rep = '{KIND_WRITE, sens_i, 7'h00, 16'sd0};
            return 1'b1;
        end
        if (cal_phase == CAL_IDLE)
            return 1'b0;
        cal_sum   += int'(smp_i);
        cal_count += 1;
        if (cal_count != AVG_COUNT)
            return 1'b0;
        avg       = cal_sum / AVG_COUNT;
        cal_sum   = 0;
        cal_count = 0;
        lim   = int'(cal_threshold);
        above = avg > lim;
        below = avg < -lim;
        if (cal_phase == CAL_FIRST)
        begin
            if (above || below)
            begin
                cal_neg   = above;
                cal_step  = STEP_ONE;
                cal_phase = CAL_STEP;
                k = KIND_WRITE;
            end
            else
            begin
                cal_phase = CAL_IDLE;
                k = KIND_DONE;
            end
        end
        else if (cal_step >= STEP_MAX)
        begin
            cal_phase = CAL_IDLE;
            k = KIND_FAIL;
        end
        else if (cal_neg ? above : below)
        begin
            cal_step = cal_step + STEP_ONE;
            k = KIND_WRITE;
        end
        else
        begin
            cal_phase = CAL_IDLE;
            k = KIND_DONE;
        end
        rep = '{k, cal_sensor, {cal_neg, cal_step}, sample_t'(avg)};
        return 1'b1;
    endfunction

    task automatic send_beat(input logic op_i, input sensor_t sens_i, input sample_t smp_i,
                             input row_mode_t mode, input cal_report_t fixed_rep);
        cal_report_t rep;
        bit          has_rep;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_i;
        sensor   <= sens_i;
        sample   <= smp_i;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!(op_i == OP_SAMPLE && cal_phase == CAL_IDLE))
            beats_taken++;
        has_rep = advance_calibration(op_i, sens_i, smp_i, rep);
        if (mode == ROW_RESULT)
            awaited_reports.push_back(fixed_rep);
        else if (mode == ROW_PREDICT && has_rep)
            awaited_reports.push_back(rep);
    endtask

    // Some sample beats yield no report, so the block may still be busy when the queue empties.
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input threshold_t value);
        settle();
        threshold_we    <= 1'b1;
        threshold_wdata <= value;
        @(posedge clk);
        threshold_we    <= 1'b0;
        cal_threshold = value;
    endtask

    task automatic check_field(input string what, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : report_side
        cal_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: unexpected beat, expected nothing, got kind %0d sensor %0d",
                         $time, kind, sensor_out);
                $display("%0t: unexpected beat, got byte %0d residual %0d",
                         $time, offset_byte, residual);
                errors++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("kind", want.kind, kind);
                check_field("sensor_out", want.sensor, sensor_out);
                check_field("offset_byte", want.obyte, offset_byte);
                check_field("residual", $signed(want.residual), $signed(residual));
            end
        end
        if (holds_served != hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    initial
    begin : stimulus
        int         row;
        int         rep;
        int         ph;
        int         n;
        int         base;
        int         amp;
        int         s;
        int         k;
        int         target;
        bit         abort;
        threshold_t ph_th;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (row = 0; row < NUM_ROWS; row++)
        begin
            for (rep = 0; rep < directed[row].reps; rep++)
            begin
                send_beat(directed[row].op, directed[row].sensor, directed[row].sample,
                          (rep == directed[row].reps - 1) ? directed[row].mode : ROW_PREDICT,
                          directed[row].report);
            end
        end
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       ph_th = '0;
                1:       ph_th = '1;
                3:       ph_th = threshold_t'($urandom_range(0, 400));
                default: ph_th = threshold_t'($urandom);
            endcase
            write_threshold(ph_th);
            calm = (ph == CALM_PHASE);
            if (ph == HOLD_PHASE)
            begin
                // Start beats each give a report, so the block fills up during the hold-off.
                hold_requests++;
                repeat (HOLD_BURST)
                    send_beat(OP_START, sensor_t'($urandom), sample_t'($urandom), ROW_PREDICT, '0);
            end
            target = beats_taken + RANDOM_ITEMS / PHASES;
            while (beats_taken < target)
            begin
                if ($urandom_range(9) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_beat(($urandom_range(7) == 0) ? OP_START : OP_SAMPLE,
                                  sensor_t'($urandom), sample_t'($urandom), ROW_PREDICT, '0);
                end
                else
                begin
                    send_beat(OP_START, sensor_t'($urandom), sample_t'($urandom), ROW_PREDICT, '0);
                    case ($urandom_range(3))
                        0:
                            base = int'(sample_t'($urandom));
                        1:
                        begin
                            base = int'(cal_threshold) + int'($urandom_range(0, 2)) - 1;
                            if ($urandom_range(1))
                                base = -base;
                        end
                        2:
                            base = $urandom_range(1) ? 32767 : -32768;
                        default:
                            base = int'($urandom_range(0, 200)) - 100;
                    endcase
                    case ($urandom_range(2))
                        0:       amp = 0;
                        1:       amp = 16;
                        default: amp = 4096;
                    endcase
                    do
                    begin
                        abort = ($urandom_range(19) == 0);
                        n = abort ? $urandom_range(1, AVG_COUNT - 1) : AVG_COUNT;
                        repeat (n)
                        begin
                            s = base + int'($urandom_range(0, 2 * amp)) - amp;
                            if (s > 32767)
                                s = 32767;
                            else if (s < -32768)
                                s = -32768;
                            send_beat(OP_SAMPLE, sensor_t'($urandom), sample_t'(s), ROW_PREDICT, '0);
                        end
                        k = $urandom_range(2, 12);
                        if (base > 0)
                            base = base - base / k - 1;
                        else if (base < 0)
                            base = base - base / k + 1;
                    end
                    while (!abort && cal_phase != CAL_IDLE && beats_taken < target);
                end
            end
        end
        calm = 1'b0;
        settle();
        if (errors == 0)
            $display("** bridge_offset_autocalibrator_unit: PASSED **");
        else
            $display("** bridge_offset_autocalibrator_unit: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #TIMEOUT_NS;
        $display("** bridge_offset_autocalibrator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/boac_pkg.sv
rtl/bridge_offset_autocalibrator_unit.sv
tb/tb_top.sv
